// ----- src/rnm_pkg.sv -----
// Shared types and constants for the nibble RSA modular exponentiation block.
// Used by the modular multiplier and the top level; no dependencies.
package rnm_pkg;

  // Fixed widths of the data ports and of the configuration port.
  localparam int DATA_W  = 31;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_ENC_EXP = 2'd1;
  localparam logic [1:0] REG_DEC_EXP = 2'd2;

  // Decimal-coded nibble constants: 1111 is the largest coded value.
  localparam int DIGIT_W   = 11;
  localparam int DIGIT_CNT = 4;

  // Modulus 2*10^k used to isolate decimal digit k, and the threshold 10^k.
  localparam logic [DIGIT_W-1:0] DIGIT_MOD [DIGIT_CNT] = '{
    11'd2, 11'd20, 11'd200, 11'd2000
  };
  localparam logic [DIGIT_W-1:0] DIGIT_THR [DIGIT_CNT] = '{
    11'd1, 11'd10, 11'd100, 11'd1000
  };

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  // Writes the four bits of a nibble as decimal digits.
  function automatic logic [DIGIT_W-1:0] nibble_to_dec(input logic [3:0] nib);
    logic [DIGIT_W-1:0] m;
    m = '0;
    if (nib[3]) m = m + DIGIT_THR[3];
    if (nib[2]) m = m + DIGIT_THR[2];
    if (nib[1]) m = m + DIGIT_THR[1];
    if (nib[0]) m = m + DIGIT_THR[0];
    return m;
  endfunction

endpackage

// ----- src/rsa_nibble_modexp_top.sv -----
// Top level of the nibble RSA block: register port, sequencer for right-to-left
// square-and-multiply, and result register. Depends on rnm_pkg and rnm_modmul.
//
//  channel   signals                                   direction
//  config    psel penable pwrite paddr pwdata prdata   APB slave, pready tied high
//  input     in_valid in_stall func data_in            one transfer per item
//  output    out_valid out_stall data_out              one transfer per item
//
// Every modular product runs on one shared bit-serial multiplier in A
// shift-subtract steps, A being OPERAND_WIDTH but at least 11, and is then
// handed over. With L the exponent's bit length an item takes at most
// 1 + 2*L products, one fewer for each clear exponent bit. Decryption adds
// four digit passes. A modulus of 0 or 1 gives a result of 0 without the
// multiplier. Input stall is high while an item is in work; a finished
// result waits in the output register and the next item is taken
// meanwhile. Reset sets all three registers to 1.
module rsa_nibble_modexp_top #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rnm_pkg::PADDR_W-1:0]   paddr,
  input  logic [rnm_pkg::PDATA_W-1:0]   pwdata,
  output logic [rnm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [rnm_pkg::DATA_W-1:0]    data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rnm_pkg::DATA_W-1:0]    data_out
);
  import rnm_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int AW = (W > DIGIT_W) ? W : DIGIT_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_REDUCE = 8'b0000_0010,
    ST_EXPCHK = 8'b0000_0100,
    ST_MULT   = 8'b0000_1000,
    ST_SQUARE = 8'b0001_0000,
    ST_POST   = 8'b0010_0000,
    ST_DIGIT  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [W-1:0]  modulus;
  logic [W-1:0]  enc_exponent;
  logic [W-1:0]  dec_exponent;
  logic          func_q;
  logic [W-1:0]  expo;
  logic [W-1:0]  acc;
  logic [W-1:0]  sq;
  logic [2:0]    nib;
  logic [1:0]    dig;
  logic [W-1:0]  result;

  logic          in_take;
  logic          cfg_wr;
  logic [1:0]    reg_idx;
  logic [W-1:0]  d_in;
  logic          dig_bit;

  logic          mm_start;
  logic [AW-1:0] mm_a;
  logic [AW-1:0] mm_b;
  logic [AW-1:0] mm_n;
  mm_stat_t      mm_stat;
  logic [AW-1:0] mm_res;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign d_in     = data_in[W-1:0];
  assign dig_bit  = (mm_res >= AW'(DIGIT_THR[dig]));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= W'(1);
      enc_exponent <= W'(1);
      dec_exponent <= W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODULUS: modulus      <= pwdata[W-1:0];
        REG_ENC_EXP: enc_exponent <= pwdata[W-1:0];
        REG_DEC_EXP: dec_exponent <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_MODULUS: prdata = PDATA_W'(modulus);
      REG_ENC_EXP: prdata = PDATA_W'(enc_exponent);
      REG_DEC_EXP: prdata = PDATA_W'(dec_exponent);
      default:     prdata = '0;
    endcase
  end

  // Launch requests for the shared multiplier.
  always_comb begin
    mm_start = 1'b0;
    mm_a     = '0;
    mm_b     = '0;
    mm_n     = AW'(modulus);
    unique case (state)
      ST_IDLE: begin
        // Reduce the base: base * 1 mod n.
        mm_start = in_take && (modulus > W'(1));
        mm_a     = func ? AW'(d_in) : AW'(nibble_to_dec(d_in[3:0]));
        mm_b     = AW'(1);
      end
      ST_EXPCHK: begin
        mm_start = (expo != '0);
        mm_a     = expo[0] ? AW'(acc) : AW'(sq);
        mm_b     = AW'(sq);
      end
      ST_MULT: begin
        mm_start = mm_stat.done;
        mm_a     = AW'(sq);
        mm_b     = AW'(sq);
      end
      ST_POST: begin
        // Decimal digit 0: value mod 2.
        mm_start = func_q;
        mm_a     = AW'(acc);
        mm_b     = AW'(1);
        mm_n     = AW'(DIGIT_MOD[0]);
      end
      ST_DIGIT: begin
        mm_start = mm_stat.done && (dig != 2'(DIGIT_CNT - 1));
        mm_a     = AW'(acc);
        mm_b     = AW'(1);
        mm_n     = AW'(DIGIT_MOD[dig + 2'd1]);
      end
      ST_REDUCE, ST_SQUARE, ST_FINISH: ;
      default: ;
    endcase
  end

  // Sequencer for square-and-multiply and digit extraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register empties on a transfer unless a new result is loaded.
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            func_q <= func;
            expo   <= func ? dec_exponent : enc_exponent;
            if (modulus > W'(1)) begin
              state <= ST_REDUCE;
            end else begin
              result <= '0;
              state  <= ST_FINISH;
            end
          end
        end
        ST_REDUCE: begin
          if (mm_stat.done) begin
            sq    <= W'(mm_res);
            acc   <= W'(1);
            state <= ST_EXPCHK;
          end
        end
        ST_EXPCHK: begin
          priority if (expo == '0) begin
            state <= ST_POST;
          end else if (expo[0]) begin
            state <= ST_MULT;
          end else begin
            state <= ST_SQUARE;
          end
        end
        ST_MULT: begin
          if (mm_stat.done) begin
            acc   <= W'(mm_res);
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mm_stat.done) begin
            sq    <= W'(mm_res);
            expo  <= expo >> 1;
            state <= ST_EXPCHK;
          end
        end
        ST_POST: begin
          if (func_q) begin
            dig   <= '0;
            state <= ST_DIGIT;
          end else begin
            result <= acc;
            state  <= ST_FINISH;
          end
        end
        ST_DIGIT: begin
          if (mm_stat.done) begin
            if (dig == 2'(DIGIT_CNT - 1)) begin
              result <= W'({dig_bit, nib});
              state  <= ST_FINISH;
            end else begin
              nib[dig] <= dig_bit;
              dig      <= dig + 2'd1;
            end
          end
        end
        ST_FINISH: begin
          // Hand over once the output register is free or being emptied.
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            data_out  <= DATA_W'(result);
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  rnm_modmul #(
    .AW (AW)
  ) u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .n     (mm_n),
    .stat  (mm_stat),
    .res   (mm_res)
  );

`ifndef SYNTH
  // The multiplier is only launched when it is free.
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier launched while busy");

  // A finished product always lands in a state that waits for it.
  a_done_used: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == ST_REDUCE || state == ST_MULT ||
                      state == ST_SQUARE || state == ST_DIGIT))
    else $error("multiplier result dropped");

  // The accumulator stays reduced throughout the exponent loop.
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPCHK) |-> (acc < modulus))
    else $error("accumulator not reduced");

  // The running square stays reduced throughout the exponent loop.
  a_sq_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPCHK) |-> (sq < modulus))
    else $error("square not reduced");
`endif

endmodule

// ----- src/rnm_modmul.sv -----
// Bit-serial interleaved modular multiplier: res = a * b mod n, with b < n.
// Depends on rnm_pkg for the status struct.
module rnm_modmul #(
  parameter int AW = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [AW-1:0]      b,
  input  logic [AW-1:0]      n,
  output rnm_pkg::mm_stat_t  stat,
  output logic [AW-1:0]      res
);
  import rnm_pkg::*;

  localparam int CW = (AW > 1) ? $clog2(AW) : 1;

  logic [AW-1:0] r;
  logic [AW-1:0] a_sh;
  logic [AW-1:0] b_q;
  logic [AW-1:0] n_q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [AW+1:0] t;
  logic [AW+1:0] n1;
  logic [AW+1:0] n2;
  logic [AW-1:0] r_next;

  // One step: double the remainder, add b when the next bit of a is set, and
  // reduce. The sum stays below 3n, so subtracting n or 2n always suffices.
  always_comb begin
    n1 = (AW+2)'(n_q);
    n2 = {1'b0, n_q, 1'b0};
    t  = {1'b0, r, 1'b0} + (a_sh[AW-1] ? (AW+2)'(b_q) : '0);
    priority if (t >= n2) begin
      r_next = AW'(t - n2);
    end else if (t >= n1) begin
      r_next = AW'(t - n1);
    end else begin
      r_next = AW'(t);
    end
  end

  // Control: count AW steps, then flag completion for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(AW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      r    <= '0;
      a_sh <= a;
      b_q  <= b;
      n_q  <= n;
    end else if (busy) begin
      r    <= r_next;
      a_sh <= a_sh << 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign res       = r;

endmodule
